/* hw/rtl/dfu_pkg.sv */
// ----------------------------------------------------------------------------
// dfu_pkg
// shared types, codes and reset values of the dfu download protocol core
// ----------------------------------------------------------------------------
`default_nettype none

package dfu_pkg;

  // default largest accepted download payload in bytes
  localparam int unsigned MAX_TRANSFER_DEF = 1024;

  // config port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_APP_LOW   = 2'd0;
  localparam logic [1:0] REG_APP_HIGH  = 2'd1;
  localparam logic [1:0] REG_XFER_SIZE = 2'd2;
  localparam logic [1:0] REG_BUSY_POLL = 2'd3;

  localparam logic [31:0] APP_LOW_RST   = 32'h0800_2000;
  localparam logic [31:0] APP_HIGH_RST  = 32'h0804_0000;
  localparam logic [10:0] XFER_SIZE_RST = 11'd1024;
  localparam logic [23:0] BUSY_POLL_RST = 24'd100;

  // protocol states
  localparam logic [3:0] ST_IDLE          = 4'd2;
  localparam logic [3:0] ST_DNLOAD_SYNC   = 4'd3;
  localparam logic [3:0] ST_DNBUSY        = 4'd4;
  localparam logic [3:0] ST_DNLOAD_IDLE   = 4'd5;
  localparam logic [3:0] ST_MANIFEST_SYNC = 4'd6;
  localparam logic [3:0] ST_MANIFEST      = 4'd7;
  localparam logic [3:0] ST_ERROR         = 4'd10;

  // class request codes
  localparam logic [7:0] REQ_DNLOAD    = 8'd1;
  localparam logic [7:0] REQ_GETSTATUS = 8'd3;
  localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
  localparam logic [7:0] REQ_GETSTATE  = 8'd5;
  localparam logic [7:0] REQ_ABORT     = 8'd6;

  // class, interface recipient (direction bit ignored)
  localparam logic [6:0] RTYPE_CLASS_IF = 7'h21;

  // block zero commands
  localparam logic [7:0] BLK0_SET_ADDRESS = 8'h21;
  localparam logic [7:0] BLK0_PAGE_ERASE  = 8'h41;

  // item kinds
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_STATUS_DONE = 1'b1;

  // flash commands
  localparam logic [1:0] FOP_NONE    = 2'd0;
  localparam logic [1:0] FOP_ERASE   = 2'd1;
  localparam logic [1:0] FOP_PROGRAM = 2'd2;

  // reply lengths
  localparam logic [2:0] RLEN_NONE   = 3'd0;
  localparam logic [2:0] RLEN_STATE  = 3'd1;
  localparam logic [2:0] RLEN_STATUS = 3'd6;

  localparam logic [7:0] STATUS_OK = 8'd0;

  typedef struct packed {
    logic [31:0] app_low;
    logic [31:0] app_high;
    logic [10:0] xfer_size;
    logic [23:0] busy_poll;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] block_number;
    logic [10:0] data_length;
    logic [7:0]  command_byte;
    logic [31:0] command_address;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        stall_res;
    logic [2:0]  reply_length;
    logic [7:0]  status_code;
    logic [23:0] poll_timeout;
    logic [3:0]  reported_state;
    logic [1:0]  flash_op;
    logic [31:0] flash_address;
    logic [10:0] flash_length;
    logic        system_reset;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/dfu_download_protocol_fsm_core.sv */
// ----------------------------------------------------------------------------
// dfu_download_protocol_fsm_core
// device side dfu download protocol engine with block zero address commands
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per control event: tuser = 0 for a class
//   request (setup fields and first five payload bytes in tdata), tuser = 1
//   when a status reply has been sent to the host.
//   m_axis returns exactly one result item per input item, in order:
//   accept/stall, reply length, status, poll timeout, new dfu state and an
//   optional erase or program command for the flash controller.
//   apb port sets the accepted address window, transfer size and the poll
//   timeout reported on entering dnbusy; write only while no item is open.
// pipeline / throughput:
//   input register, one combinational decode step, output register: the
//   result is written to the output register once the output slot is free;
//   one item is taken every cycle while m_axis is not stalled, and the
//   decode step (32x11 block offset multiply plus base add) sets the cycle time.
// reset: state returns to dfuIDLE, pending block cleared, registers take
//   their default values, both stream stages empty.
// stall: a held result keeps the output register; one more item waits in
//   the input register, then s_axis_tready drops until m_axis moves again.
// ----------------------------------------------------------------------------
`default_nettype none

module dfu_download_protocol_fsm_core #(
  parameter int unsigned MAX_TRANSFER = dfu_pkg::MAX_TRANSFER_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input items
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // request_type, request_code, block_number, data_length, command_byte,
  // command_address (from bit 0 up), zero padded to 88 bits
  input  wire logic [87:0]                     s_axis_tdata,
  // action
  input  wire logic                            s_axis_tuser,
  // result items
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // accepted, stall_res, reply_length, status_code, poll_timeout,
  // reported_state, flash_op, flash_address, flash_length, system_reset
  // (from bit 0 up), zero padded to 88 bits
  output      logic [87:0]                     m_axis_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dfu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [dfu_pkg::CFG_DATA_W-1:0]  pwdata,
  output      logic [dfu_pkg::CFG_DATA_W-1:0]  prdata,
  output      logic                            pready
);

  dfu_pkg::cfg_t    cfg;
  dfu_pkg::item_t   in_item, item_q;
  dfu_pkg::result_t step_res, res_q;

  logic in_valid_q;
  logic out_valid_q;
  logic s_accept;
  logic advance;

  // register block
  dfu_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // unpack input item
  always_comb begin
    in_item.action          = s_axis_tuser;
    in_item.request_type    = s_axis_tdata[7:0];
    in_item.request_code    = s_axis_tdata[15:8];
    in_item.block_number    = s_axis_tdata[31:16];
    in_item.data_length     = s_axis_tdata[42:32];
    in_item.command_byte    = s_axis_tdata[50:43];
    in_item.command_address = s_axis_tdata[82:51];
  end

  // the decode step fires when an item waits and the output slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q <= in_item;
    end
  end

  // protocol state and decode
  dfu_engine #(
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  // pack result item
  assign m_axis_tdata = {
    1'b0,
    res_q.system_reset,
    res_q.flash_length,
    res_q.flash_address,
    res_q.flash_op,
    res_q.reported_state,
    res_q.poll_timeout,
    res_q.status_code,
    res_q.reply_length,
    res_q.stall_res,
    res_q.accepted
  };

`ifndef SYNTHESIS
  // a stall is always a refusal
  a_stall_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.stall_res |-> !res_q.accepted)
    else $error("stall reported on an accepted item");

  // reset request only comes out of manifest
  a_reset_in_manifest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.system_reset |-> res_q.reported_state == dfu_pkg::ST_MANIFEST)
    else $error("system reset outside manifest");

  // flash command leaves dnbusy for dnload idle
  a_flash_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.flash_op != dfu_pkg::FOP_NONE)
      |-> res_q.reported_state == dfu_pkg::ST_DNLOAD_IDLE)
    else $error("flash command with wrong state");

  // a waiting item is never dropped while the output is blocked
  a_item_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("waiting item lost");

  // a result is only written when the output slot is free
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !out_valid_q || m_axis_tready)
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dfu_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dfu_cfg_regs
// apb register file holding address window, transfer size and poll timeout
// ----------------------------------------------------------------------------
`default_nettype none

module dfu_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel_i,
  input  wire logic                               penable_i,
  input  wire logic                               pwrite_i,
  input  wire logic [dfu_pkg::CFG_ADDR_W-1:0]     paddr_i,
  input  wire logic [dfu_pkg::CFG_DATA_W-1:0]     pwdata_i,
  output      logic [dfu_pkg::CFG_DATA_W-1:0]     prdata_o,
  output      logic                               pready_o,
  output      dfu_pkg::cfg_t                      cfg_o
);

  dfu_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign reg_sel  = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.app_low   <= dfu_pkg::APP_LOW_RST;
      cfg_q.app_high  <= dfu_pkg::APP_HIGH_RST;
      cfg_q.xfer_size <= dfu_pkg::XFER_SIZE_RST;
      cfg_q.busy_poll <= dfu_pkg::BUSY_POLL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        dfu_pkg::REG_APP_LOW:   cfg_q.app_low   <= pwdata_i;
        dfu_pkg::REG_APP_HIGH:  cfg_q.app_high  <= pwdata_i;
        dfu_pkg::REG_XFER_SIZE: cfg_q.xfer_size <= pwdata_i[10:0];
        dfu_pkg::REG_BUSY_POLL: cfg_q.busy_poll <= pwdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dfu_pkg::REG_APP_LOW:   prdata_o = cfg_q.app_low;
      dfu_pkg::REG_APP_HIGH:  prdata_o = cfg_q.app_high;
      dfu_pkg::REG_XFER_SIZE: prdata_o = {21'd0, cfg_q.xfer_size};
      dfu_pkg::REG_BUSY_POLL: prdata_o = {8'd0, cfg_q.busy_poll};
      default:                prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/dfu_engine.sv */
// ----------------------------------------------------------------------------
// dfu_engine
// protocol state, pending block and the one-step request/completion decode
// ----------------------------------------------------------------------------
`default_nettype none

module dfu_engine #(
  parameter int unsigned MAX_TRANSFER = dfu_pkg::MAX_TRANSFER_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire dfu_pkg::item_t   item_i,
  input  wire dfu_pkg::cfg_t    cfg_i,
  output      dfu_pkg::result_t res_o
);

  logic [3:0]  state_q, state_d;
  logic [15:0] pblock_q, pblock_d;
  logic [10:0] plen_q, plen_d;
  logic [7:0]  pcmd_q, pcmd_d;
  logic [31:0] paddr_q, paddr_d;
  logic [31:0] base_q, base_d;

  logic [31:0] blk_m2;
  logic [31:0] blk_offs;
  logic        addr_ok;
  logic        len_ok;

  // block address stepping, wraps mod 2^32
  assign blk_m2   = {16'd0, pblock_q} - 32'd2;
  assign blk_offs = blk_m2 * {21'd0, cfg_i.xfer_size};
  assign addr_ok  = (paddr_q >= cfg_i.app_low) && (paddr_q < cfg_i.app_high);
  assign len_ok   = {21'd0, item_i.data_length} <= 32'(MAX_TRANSFER);

  always_comb begin
    state_d  = state_q;
    pblock_d = pblock_q;
    plen_d   = plen_q;
    pcmd_d   = pcmd_q;
    paddr_d  = paddr_q;
    base_d   = base_q;

    res_o                = '0;
    res_o.status_code    = dfu_pkg::STATUS_OK;
    res_o.reply_length   = dfu_pkg::RLEN_NONE;
    res_o.flash_op       = dfu_pkg::FOP_NONE;

    if (item_i.action == dfu_pkg::ACT_REQUEST) begin
      if (item_i.request_type[6:0] == dfu_pkg::RTYPE_CLASS_IF) begin
        unique case (item_i.request_code)
          dfu_pkg::REQ_DNLOAD: begin
            if (item_i.data_length == 11'd0) begin
              state_d        = dfu_pkg::ST_MANIFEST_SYNC;
              res_o.accepted = 1'b1;
            end else if (len_ok) begin
              pblock_d       = item_i.block_number;
              plen_d         = item_i.data_length;
              pcmd_d         = item_i.command_byte;
              paddr_d        = item_i.command_address;
              state_d        = dfu_pkg::ST_DNLOAD_SYNC;
              res_o.accepted = 1'b1;
            end
          end
          dfu_pkg::REQ_GETSTATUS: begin
            priority if (state_q == dfu_pkg::ST_DNLOAD_SYNC) begin
              state_d            = dfu_pkg::ST_DNBUSY;
              res_o.poll_timeout = cfg_i.busy_poll;
            end else if (state_q == dfu_pkg::ST_MANIFEST_SYNC) begin
              state_d = dfu_pkg::ST_MANIFEST;
            end else begin
            end
            res_o.reply_length = dfu_pkg::RLEN_STATUS;
            res_o.accepted     = 1'b1;
          end
          dfu_pkg::REQ_CLRSTATUS: begin
            if (state_q == dfu_pkg::ST_ERROR) state_d = dfu_pkg::ST_IDLE;
            res_o.accepted = 1'b1;
          end
          dfu_pkg::REQ_GETSTATE: begin
            res_o.reply_length = dfu_pkg::RLEN_STATE;
            res_o.accepted     = 1'b1;
          end
          dfu_pkg::REQ_ABORT: begin
            state_d        = dfu_pkg::ST_IDLE;
            res_o.accepted = 1'b1;
          end
          default: ;
        endcase
      end
    end else begin
      // status reply went out
      res_o.accepted = 1'b1;
      priority if (state_q == dfu_pkg::ST_DNBUSY) begin
        if (pblock_q == 16'd0) begin
          if (!addr_ok) begin
            res_o.stall_res = 1'b1;
            res_o.accepted  = 1'b0;
          end else begin
            if (pcmd_q == dfu_pkg::BLK0_PAGE_ERASE) begin
              res_o.flash_op      = dfu_pkg::FOP_ERASE;
              res_o.flash_address = paddr_q;
              base_d              = paddr_q;
            end else if (pcmd_q == dfu_pkg::BLK0_SET_ADDRESS) begin
              base_d = paddr_q;
            end
            state_d = dfu_pkg::ST_DNLOAD_IDLE;
          end
        end else begin
          res_o.flash_op      = dfu_pkg::FOP_PROGRAM;
          res_o.flash_address = base_q + blk_offs;
          res_o.flash_length  = plen_q;
          state_d             = dfu_pkg::ST_DNLOAD_IDLE;
        end
      end else if (state_q == dfu_pkg::ST_MANIFEST) begin
        res_o.system_reset = 1'b1;
      end else begin
      end
    end

    res_o.reported_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dfu_pkg::ST_IDLE;
      pblock_q <= '0;
      plen_q   <= '0;
      pcmd_q   <= '0;
      paddr_q  <= '0;
      base_q   <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      pblock_q <= pblock_d;
      plen_q   <= plen_d;
      pcmd_q   <= pcmd_d;
      paddr_q  <= paddr_d;
      base_q   <= base_d;
    end
  end

endmodule

`default_nettype wire
